/* rtl/matrix_multiply_stream_core_defines.svh */
// Assertion macros shared by the matrix multiply stream RTL.
`ifndef MATRIX_MULTIPLY_STREAM_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_STREAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MMS_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mms: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define MMS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mms: next-cycle check failed");
`else
`define MMS_ASSERT_IMP(name, clk, rst_n, pre, post)
`define MMS_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

/* rtl/mms_pkg.sv */
// Constants, widths and codes of the matrix multiply stream block.
`timescale 1ns / 1ps

package mms_pkg;

  // Sizing of the stores.
  localparam int MAX_INNER   = 256;
  localparam int MAX_COLUMNS = 64;
  localparam int STORE_DEPTH = MAX_INNER * MAX_COLUMNS;

  // Fixed field and register widths.
  localparam int VALUE_W     = 16;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int ACC_W       = 40;
  localparam int COL_IDX_W   = 6;
  localparam int INNER_REG_W = 9;
  localparam int COLS_REG_W  = 7;
  localparam int ROWS_REG_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Widths derived from the store sizes.
  localparam int RIDX_W      = $clog2(MAX_INNER);
  localparam int INNER_CNT_W = $clog2(MAX_INNER + 1);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int COLS_CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int TOTAL_W     = INNER_CNT_W + COLS_CNT_W;

  // Input command codes.
  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_ROW    = 1'b1
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER   = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ROWS    = 2'd2
  } cfg_idx_e;

endpackage

/* rtl/mms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/matrix_multiply_stream_core.sv */
// Top level of the streaming matrix multiply with one shared multiply-accumulate unit.
`timescale 1ns / 1ps
`include "matrix_multiply_stream_core_defines.svh"

// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   command_i, value_i
// out       out_valid_o / out_stall_i product_sum_o, column_index_o, row_last_o, matrix_last_o
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A weight load or a row element that does not end a row leaves the block idle and ready.
// The element that ends a row starts a busy pass over every column, which any output stall
// stretches: one multiplier and one accumulator walk every product.
// Both stores are RAMs with no reset, so the block takes items right after reset.
// The last result may sit in the output register while the next item is taken.

module matrix_multiply_stream_core import mms_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input item channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    command_i,
  input  logic signed [VALUE_W-1:0] value_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ACC_W-1:0] product_sum_o,
  output logic [COL_IDX_W-1:0]    column_index_o,
  output logic                    row_last_o,
  output logic                    matrix_last_o,
  // Configuration write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration and position registers.
  logic [INNER_REG_W-1:0] inner_cfg_q;
  logic [COLS_REG_W-1:0]  cols_cfg_q;
  logic [ROWS_REG_W-1:0]  rows_cfg_q;
  logic [STORE_AW-1:0]    wpos_q;
  logic [RIDX_W-1:0]      rpos_q;
  logic [ROWS_REG_W-1:0]  rows_done_q;

  // Sequencer and datapath registers.
  logic [RIDX_W-1:0]        rd_idx_q;
  logic [STORE_AW-1:0]      wt_addr_q;
  logic [COL_W-1:0]         col_q;
  logic                     mlast_q;
  logic                     v1_q;
  logic                     v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         acc_q;

  // Output register.
  logic                 out_valid_q;
  logic [ACC_W-1:0]     out_sum_q;
  logic [COL_W-1:0]     out_col_q;
  logic                 row_last_q;
  logic                 matrix_last_q;

  // Combinational helpers.
  logic [INNER_CNT_W-1:0]  eff_inner;
  logic [COLS_CNT_W-1:0]   eff_cols;
  logic [ROWS_REG_W-1:0]   eff_rows;
  logic [TOTAL_W-1:0]      total;
  logic [STORE_AW-1:0]     wpos_base;
  logic [TOTAL_W-1:0]      wpos_inc;
  logic [STORE_AW-1:0]     wpos_wrap;
  logic [RIDX_W-1:0]       rpos_base;
  logic [INNER_CNT_W-1:0]  rpos_inc;
  logic                    row_done;
  logic [ROWS_REG_W:0]     rows_inc;
  logic                    matrix_end;
  logic                    in_xfer;
  logic                    cfg_xfer;
  logic                    cfg_hit;
  logic                    weight_we;
  logic                    row_we;
  logic                    issue;
  logic                    last_issue;
  logic                    col_last;
  logic                    out_free;
  logic signed [VALUE_W-1:0] row_rdata;
  logic signed [VALUE_W-1:0] wt_rdata;

  // Register values clamped to their legal ranges.
  always_comb begin
    if (inner_cfg_q == '0) begin
      eff_inner = INNER_CNT_W'(1);
    end else if (32'(inner_cfg_q) > 32'(MAX_INNER)) begin
      eff_inner = INNER_CNT_W'(MAX_INNER);
    end else begin
      eff_inner = INNER_CNT_W'(inner_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      eff_cols = COLS_CNT_W'(1);
    end else if (32'(cols_cfg_q) > 32'(MAX_COLUMNS)) begin
      eff_cols = COLS_CNT_W'(MAX_COLUMNS);
    end else begin
      eff_cols = COLS_CNT_W'(cols_cfg_q);
    end
    eff_rows = (rows_cfg_q == '0) ? ROWS_REG_W'(1) : rows_cfg_q;
  end

  assign total = TOTAL_W'(eff_inner) * TOTAL_W'(eff_cols);

  // Weight load position with wrap after a full matrix of weights.
  assign wpos_base = (TOTAL_W'(wpos_q) >= total) ? '0 : wpos_q;
  assign wpos_inc  = TOTAL_W'(wpos_base) + TOTAL_W'(1);
  assign wpos_wrap = (wpos_inc >= total) ? '0 : STORE_AW'(wpos_inc);

  // Row position and row/matrix completion.
  assign rpos_base  = (INNER_CNT_W'(rpos_q) >= eff_inner) ? '0 : rpos_q;
  assign rpos_inc   = INNER_CNT_W'(rpos_base) + INNER_CNT_W'(1);
  assign row_done   = (rpos_inc >= eff_inner);
  assign rows_inc   = (ROWS_REG_W + 1)'(rows_done_q) + (ROWS_REG_W + 1)'(1);
  assign matrix_end = (rows_inc >= (ROWS_REG_W + 1)'(eff_rows));

  // Handshakes.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_xfer && (cfg_index_i inside {CFG_INNER, CFG_COLUMNS, CFG_ROWS});
  assign weight_we   = in_xfer && (command_i == CMD_WEIGHT);
  assign row_we      = in_xfer && (command_i == CMD_ROW);

  // Sequencer conditions.
  assign issue      = (state_q == ST_ISSUE);
  assign last_issue = (INNER_CNT_W'(rd_idx_q) + INNER_CNT_W'(1)) == eff_inner;
  assign col_last   = (COLS_CNT_W'(col_q) + COLS_CNT_W'(1)) == eff_cols;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Row buffer: written by row elements, read once per product.
  mms_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_INNER)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (rpos_base),
    .wdata_i (value_i),
    .re_i    (issue),
    .raddr_i (rd_idx_q),
    .rdata_o (row_rdata)
  );

  // Weight store in row-major order.
  mms_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(STORE_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (weight_we),
    .waddr_i (wpos_base),
    .wdata_i (value_i),
    .re_i    (issue),
    .raddr_i (wt_addr_q),
    .rdata_o (wt_rdata)
  );

  // Shared multiplier, registered before the accumulator.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= row_rdata * wt_rdata;
    end
  end

  // Configuration registers and load positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_cfg_q <= INNER_REG_W'(1);
      cols_cfg_q  <= COLS_REG_W'(1);
      rows_cfg_q  <= ROWS_REG_W'(1);
      wpos_q      <= '0;
      rpos_q      <= '0;
      rows_done_q <= '0;
    end else begin
      if (weight_we) begin
        wpos_q <= wpos_wrap;
      end
      if (row_we) begin
        if (row_done) begin
          rpos_q      <= '0;
          rows_done_q <= matrix_end ? '0 : ROWS_REG_W'(rows_inc);
        end else begin
          rpos_q <= RIDX_W'(rpos_inc);
        end
      end
      if (cfg_xfer) begin
        case (cfg_index_i)
          CFG_INNER:   inner_cfg_q <= cfg_data_i[INNER_REG_W-1:0];
          CFG_COLUMNS: cols_cfg_q  <= cfg_data_i[COLS_REG_W-1:0];
          CFG_ROWS:    rows_cfg_q  <= cfg_data_i[ROWS_REG_W-1:0];
          default:     ;
        endcase
      end
      // A write to a known register restarts all load positions.
      if (cfg_hit) begin
        wpos_q      <= '0;
        rpos_q      <= '0;
        rows_done_q <= '0;
      end
    end
  end

  // Sequencer: issue one product per cycle, drain the pipe, hand off the column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rd_idx_q      <= '0;
      wt_addr_q     <= '0;
      col_q         <= '0;
      mlast_q       <= 1'b0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      acc_q         <= '0;
      out_valid_q   <= 1'b0;
      out_sum_q     <= '0;
      out_col_q     <= '0;
      row_last_q    <= 1'b0;
      matrix_last_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (row_we && row_done) begin
            state_q   <= ST_ISSUE;
            col_q     <= '0;
            rd_idx_q  <= '0;
            wt_addr_q <= '0;
            acc_q     <= '0;
            mlast_q   <= matrix_end;
          end
        end
        ST_ISSUE: begin
          rd_idx_q  <= rd_idx_q + RIDX_W'(1);
          wt_addr_q <= wt_addr_q + STORE_AW'(eff_cols);
          if (last_issue) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_sum_q     <= acc_q;
            out_col_q     <= col_q;
            row_last_q    <= col_last;
            matrix_last_q <= col_last && mlast_q;
            if (col_last) begin
              state_q <= ST_IDLE;
            end else begin
              col_q     <= col_q + COL_W'(1);
              rd_idx_q  <= '0;
              wt_addr_q <= STORE_AW'(col_q) + STORE_AW'(1);
              acc_q     <= '0;
              state_q   <= ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result ports.
  assign out_valid_o    = out_valid_q;
  assign product_sum_o  = out_sum_q;
  assign column_index_o = COL_IDX_W'(out_col_q);
  assign row_last_o     = row_last_q;
  assign matrix_last_o  = matrix_last_q;

  // A completed row always starts the multiply-accumulate pass.
  `MMS_ASSERT_NEXT(a_row_starts_mac, clk_i, rst_ni, row_we && row_done, state_q == ST_ISSUE)
  // The product pipe is empty whenever new items can be taken.
  `MMS_ASSERT_IMP(a_idle_pipe_empty, clk_i, rst_ni, state_q == ST_IDLE, !v1_q && !v2_q)
  // Handing off the last column returns to idle with the row-end result shown.
  `MMS_ASSERT_NEXT(a_last_col_idle, clk_i, rst_ni,
                   state_q == ST_EMIT && out_free && col_last,
                   state_q == ST_IDLE && out_valid_q && row_last_q)

endmodule

/* dv/matrix_multiply_stream_core_tb.sv */
// Self-checking testbench for the streaming matrix multiply core.
`timescale 1ns / 1ps

module matrix_multiply_stream_core_tb;
  import mms_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 140;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int DIRECTED_ROWS = 24;

  // The index above the last register decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] MIN_Q15 = 16'sh8000;
  localparam logic signed [VALUE_W-1:0] MAX_Q15 = 16'sh7FFF;

  typedef struct {
    logic signed [ACC_W-1:0] sum;
    logic [COL_IDX_W-1:0]    column;
    logic                    row_end;
    logic                    matrix_end;
  } dot_result_t;

  typedef enum logic {
    STEP_ITEM,
    STEP_REG
  } step_kind_e;

  // One row of the directed table: an input transfer or a register write.
  typedef struct {
    step_kind_e              kind;
    logic [CFG_IDX_W-1:0]    code;
    logic [CFG_DATA_W-1:0]   data;
    logic                    typed;
    logic signed [ACC_W-1:0] typed_sum;
  } dir_step_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     command_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [ACC_W-1:0]  product_sum_o;
  logic [COL_IDX_W-1:0]     column_index_o;
  logic                     row_last_o;
  logic                     matrix_last_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  matrix_multiply_stream_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .product_sum_o  (product_sum_o),
    .column_index_o (column_index_o),
    .row_last_o     (row_last_o),
    .matrix_last_o  (matrix_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the block's stores, pointers and registers.
  logic signed [VALUE_W-1:0] weight_mem [STORE_DEPTH];
  logic signed [VALUE_W-1:0] row_mem [MAX_INNER];
  int unsigned               load_ptr;
  int unsigned               elem_ptr;
  int unsigned               rows_seen;
  logic [INNER_REG_W-1:0]    inner_reg;
  logic [COLS_REG_W-1:0]     cols_reg;
  logic [ROWS_REG_W-1:0]     rows_reg;

  dot_result_t pending_dots [$];
  dir_step_t   directed_steps [DIRECTED_ROWS];

  int  mismatches;
  int  items_sent;
  int  dots_seen;
  int  reg_writes;
  int  cycle_count;
  int  feed_calm;
  bit  hold_req;

  // Effective sizes after clamping of the raw register contents.
  function automatic int unsigned active_inner();
    if (inner_reg == 0) return 1;
    if (inner_reg > MAX_INNER) return MAX_INNER;
    return inner_reg;
  endfunction

  function automatic int unsigned active_columns();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return cols_reg;
  endfunction

  function automatic int unsigned active_rows();
    return (rows_reg == 0) ? 1 : rows_reg;
  endfunction

  // Register write: every decoded index also rewinds the pointers.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_INNER:   inner_reg = data[INNER_REG_W-1:0];
      CFG_COLUMNS: cols_reg = data[COLS_REG_W-1:0];
      CFG_ROWS:    rows_reg = data[ROWS_REG_W-1:0];
      default:     return;
    endcase
    load_ptr  = 0;
    elem_ptr  = 0;
    rows_seen = 0;
  endfunction

  // Weight loads fill the store in row-major order; the element that ends a row
  // yields one dot product per column.
  function automatic void apply_item(cmd_e cmd, logic signed [VALUE_W-1:0] val);
    int unsigned             n_in;
    int unsigned             n_col;
    int unsigned             total;
    logic signed [ACC_W-1:0] sum;
    dot_result_t             dot;
    bit                      ends_matrix;
    n_in  = active_inner();
    n_col = active_columns();
    if (cmd == CMD_WEIGHT) begin
      total = n_in * n_col;
      if (load_ptr >= total) load_ptr = 0;
      weight_mem[load_ptr] = val;
      load_ptr++;
      if (load_ptr >= total) load_ptr = 0;
    end else begin
      if (elem_ptr >= n_in) elem_ptr = 0;
      row_mem[elem_ptr] = val;
      elem_ptr++;
      if (elem_ptr == n_in) begin
        elem_ptr = 0;
        rows_seen++;
        ends_matrix = (rows_seen >= active_rows());
        if (ends_matrix) rows_seen = 0;
        for (int unsigned c = 0; c < n_col; c++) begin
          sum = '0;
          for (int unsigned i = 0; i < n_in; i++) begin
            sum += row_mem[i] * weight_mem[i * n_col + c];
          end
          dot.sum        = sum;
          dot.column     = COL_IDX_W'(c);
          dot.row_end    = (c + 1 == n_col);
          dot.matrix_end = (c + 1 == n_col) && ends_matrix;
          pending_dots.push_back(dot);
        end
      end
    end
  endfunction

  // Gap lengths: mostly none or short, a few long, and calm stretches without gaps.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Element values lean toward the Q1.15 extremes.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return MIN_Q15;
      1:       return MAX_Q15;
      2:       return '0;
      3:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic void check_field(string field, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // One input transfer, after an optional gap with valid low.
  task automatic send_item(input cmd_e cmd, input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = pick_gap(feed_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    apply_item(cmd, val);
  endtask

  // One register write; valid stays high when another write follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    reg_writes++;
    apply_reg(idx, data);
  endtask

  // Wait until every expected result is out and the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // A full weight load, then whole rows with stray weight loads mixed in,
  // sometimes ending on a partial row that the next register write drops.
  task automatic random_phase(input logic [CFG_DATA_W-1:0] inner_data,
                              input logic [CFG_DATA_W-1:0] cols_data,
                              input logic [CFG_DATA_W-1:0] rows_data,
                              input int row_total, input bit pin_min);
    int unsigned n_in;
    int unsigned n_col;
    settle();
    write_reg(CFG_INNER, inner_data, 1'b0);
    write_reg(CFG_COLUMNS, cols_data, 1'b0);
    write_reg(CFG_ROWS, rows_data, 1'b1);
    n_in  = active_inner();
    n_col = active_columns();
    repeat (n_in * n_col) send_item(CMD_WEIGHT, pin_min ? MIN_Q15 : pick_value());
    repeat (row_total) begin
      repeat (n_in) begin
        if (!pin_min && $urandom_range(0, 7) == 0) send_item(CMD_WEIGHT, pick_value());
        send_item(CMD_ROW, pin_min ? MIN_Q15 : pick_value());
      end
    end
    if (!pin_min && n_in > 1 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, n_in - 1)) send_item(CMD_ROW, pick_value());
    end
  endtask

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall pattern, plus one long hold on request.
  initial begin : drain_side
    int gap;
    int calm;
    calm = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = pick_gap(calm);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    dot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      dots_seen++;
      if (pending_dots.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual sum %0d column %0d",
                 $time, product_sum_o, column_index_o);
      end else begin
        want = pending_dots.pop_front();
        check_field("product_sum", want.sum, product_sum_o);
        check_field("column_index", want.column, column_index_o);
        check_field("row_last", want.row_end, row_last_o);
        check_field("matrix_last", want.matrix_end, matrix_last_o);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, size extremes.
  initial begin
    int unsigned n_in;
    int unsigned n_col;
    int          directed_items;
    bit          wide;

    mismatches  = 0;
    items_sent  = 0;
    dots_seen   = 0;
    reg_writes  = 0;
    cycle_count = 0;
    feed_calm   = 0;
    hold_req    = 1'b0;
    load_ptr    = 0;
    elem_ptr    = 0;
    rows_seen   = 0;
    inner_reg   = 1;
    cols_reg    = 1;
    rows_reg    = 1;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    command_i   <= CMD_WEIGHT;
    value_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_INNER;
    cfg_data_i  <= '0;

    // Sizes start at one; typed sums are plain products of Q1.15 extremes.
    directed_steps = '{
      '{STEP_ITEM, CMD_WEIGHT,  16'h7FFF, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h7FFF, 1'b1, 40'sd1073676289},
      '{STEP_ITEM, CMD_WEIGHT,  16'h8000, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h8000, 1'b1, 40'sd1073741824},
      '{STEP_ITEM, CMD_ROW,     16'h7FFF, 1'b1, -40'sd1073709056},
      // Zero in every register acts as one; the store keeps its contents.
      '{STEP_REG,  CFG_INNER,   16'h0000, 1'b0, 40'sd0},
      '{STEP_REG,  CFG_COLUMNS, 16'h0000, 1'b0, 40'sd0},
      '{STEP_REG,  CFG_ROWS,    16'h0000, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h0001, 1'b1, -40'sd32768},
      // Two-element rows; the third weight wraps back onto the first entry.
      '{STEP_REG,  CFG_INNER,   16'h0002, 1'b0, 40'sd0},
      '{STEP_REG,  CFG_ROWS,    16'h0002, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_WEIGHT,  16'h0001, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_WEIGHT,  16'hFFFF, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_WEIGHT,  16'h0005, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h0003, 1'b0, 40'sd0},
      // A write to the undecoded index leaves the half-done row alone.
      '{STEP_REG,  CFG_UNUSED,  16'hFFFF, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h0004, 1'b1, 40'sd11},
      // A weight load between two elements of the same row.
      '{STEP_ITEM, CMD_ROW,     16'hFFFE, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_WEIGHT,  16'h0007, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h000A, 1'b0, 40'sd0},
      // A register write drops the partial row.
      '{STEP_ITEM, CMD_ROW,     16'h0009, 1'b0, 40'sd0},
      '{STEP_REG,  CFG_ROWS,    16'h0001, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h0001, 1'b0, 40'sd0},
      '{STEP_ITEM, CMD_ROW,     16'h0001, 1'b0, 40'sd0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed_steps[k].kind == STEP_REG) begin
        if (k == 0 || directed_steps[k-1].kind != STEP_REG) settle();
        write_reg(directed_steps[k].code, directed_steps[k].data,
                  k + 1 == DIRECTED_ROWS || directed_steps[k+1].kind != STEP_REG);
      end else begin
        send_item(cmd_e'(directed_steps[k].code[0]), directed_steps[k].data);
        if (directed_steps[k].typed) begin
          pending_dots[pending_dots.size()-1].sum = directed_steps[k].typed_sum;
        end
      end
    end
    directed_items = items_sent;

    // The result side holds off while full rows keep arriving.
    hold_req = 1'b1;
    random_phase(16'd2, 16'd8, 16'd3, 6, 1'b0);

    // Random sizes, with clamped zeros and junk in the unused data bits.
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      wide  = ($urandom_range(0, 5) == 0);
      n_col = wide ? $urandom_range(9, 64) : $urandom_range(1, 6);
      if (wide) n_in = $urandom_range(1, 2);
      else if ($urandom_range(0, 5) == 0) n_in = $urandom_range(7, 16);
      else n_in = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) n_in = 0;
      if ($urandom_range(0, 9) == 0) n_col = 0;
      random_phase({7'($urandom), 9'(n_in)}, {9'($urandom), 7'(n_col)},
                   ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)),
                   $urandom_range(1, 6), 1'b0);
    end

    // Widest rows with the largest row count, then deeper rows at full scale.
    random_phase(16'd1, 16'hFFFF, 16'hFFFF, 3, 1'b0);
    random_phase(16'd32, 16'd1, 16'd1, 1, 1'b1);

    settle();

    $display("Sent %0d input transfers and %0d register writes; checked %0d results.",
             items_sent, reg_writes, dots_seen);
    $display("Sizes ran from clamped zeros to 64 columns and 32-element rows at full scale.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* matrix_multiply_stream_core.f */
+incdir+rtl
rtl/mms_pkg.sv
rtl/mms_ram.sv
rtl/matrix_multiply_stream_core.sv
dv/matrix_multiply_stream_core_tb.sv
